FILE: hw/rtl/scc_pkg.sv
package scc_pkg;

	localparam int VertexW = 6;
	localparam int AreaW   = 7;
	localparam int PlacesW = 7;

	localparam logic [1:0] OP_BASE  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_EVAL  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE_W1,
		ST_EDGE_R2,
		ST_EDGE_W2,
		ST_P1_SEL,
		ST_P1_EXP,
		ST_P1_POP,
		ST_P2_INIT,
		ST_P2_S,
		ST_P2_EXP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [AreaW-1:0] area_count;
	} res_t;

endpackage

FILE: hw/rtl/scc_adj_ram.sv
module scc_adj_ram #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clr,
	input  logic                             rd_en,
	input  logic [$clog2(MAX_VERTICES)-1:0]  rd_addr,
	input  logic                             we,
	input  logic [$clog2(MAX_VERTICES)-1:0]  wr_addr,
	input  logic [2*MAX_VERTICES-1:0]        wr_data,
	output logic [2*MAX_VERTICES-1:0]        rd_data
);

	logic [2*MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [2*MAX_VERTICES-1:0] rd_q;
	logic [MAX_VERTICES-1:0]   vld_q;
	logic                      rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_s1 ? rd_q : '0;

endmodule

FILE: hw/rtl/scc_ctrl.sv
module scc_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       in_op,
	input  logic [scc_pkg::VertexW-1:0]      in_from,
	input  logic [scc_pkg::VertexW-1:0]      in_to,
	input  logic [MAX_VERTICES-1:0]          place_mask,
	output scc_pkg::res_t                    res,
	input  logic                             res_ack,
	output logic                             rd_en,
	output logic [$clog2(MAX_VERTICES)-1:0]  rd_addr,
	output logic [$clog2(MAX_VERTICES)-1:0]  wr_addr,
	output logic [2*MAX_VERTICES-1:0]        wr_data,
	output logic                             base_we,
	output logic                             qry_we,
	output logic                             qry_clr,
	input  logic [2*MAX_VERTICES-1:0]        base_rd,
	input  logic [2*MAX_VERTICES-1:0]        qry_rd
);

	localparam int N  = MAX_VERTICES;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [2*N-1:0] RowOne = 1;
	localparam logic [N-1:0]   VecOne = 1;

	function automatic logic [VW-1:0] first_one(input logic [N-1:0] x);
		logic [VW-1:0] r;
		r = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (x[i]) begin
				r = VW'(i);
			end
		end
		return r;
	endfunction

	scc_pkg::state_t state_q, state_d;

	logic [1:0]          op_q;
	logic [VW-1:0]       from_q, to_q, top_q, sp_q, sp_dec, stk_rd_q, fin_rd_q, first;
	logic [CW-1:0]       fin_q, fin_dec, count_q;
	logic [N-1:0]        visited_q, extra_q, pend_q, active, newb, cand;
	logic [VW-1:0]       stk_mem [N];
	logic [VW-1:0]       fin_mem [N];
	logic [2*N-1:0]      row_rd, rd_sel;
	logic [N-1:0]        out_bits, in_bits;
	logic                accept, edge_ok, cand_any, s_seen, nxt_fin, stk_re, fin_re;
	logic [VW-1:0]       in_from_a, in_to_a;

	assign accept    = in_valid && in_ready;
	assign edge_ok   = (32'(in_from) < MAX_VERTICES) && (32'(in_to) < MAX_VERTICES)
		&& (in_op == scc_pkg::OP_BASE || in_op == scc_pkg::OP_QUERY);
	assign in_from_a = VW'(in_from);
	assign in_to_a   = VW'(in_to);
	assign row_rd    = base_rd | qry_rd;
	assign rd_sel    = (op_q == scc_pkg::OP_BASE) ? base_rd : qry_rd;
	assign out_bits  = row_rd[N-1:0];
	assign in_bits   = row_rd[2*N-1:N];
	assign active    = place_mask | extra_q;
	assign newb      = in_bits & active & ~visited_q;
	assign sp_dec    = sp_q - 1'b1;
	assign fin_dec   = fin_q - 1'b1;
	assign s_seen    = visited_q[fin_rd_q];

	always_comb begin
		unique case (state_q)
			scc_pkg::ST_P1_SEL: cand = active & ~visited_q;
			scc_pkg::ST_P1_EXP: cand = out_bits & active & ~visited_q;
			scc_pkg::ST_P2_EXP: cand = pend_q | newb;
			default:            cand = '0;
		endcase
	end

	assign cand_any = |cand;
	assign first    = first_one(cand);
	assign nxt_fin  = (state_q == scc_pkg::ST_P2_S && s_seen)
		|| (state_q == scc_pkg::ST_P2_EXP && !cand_any);
	assign fin_re   = (state_q == scc_pkg::ST_P2_INIT || nxt_fin) && fin_q != '0;
	assign stk_re   = state_q == scc_pkg::ST_P1_EXP && !cand_any && sp_q != '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				if (accept && edge_ok) begin
					state_d = scc_pkg::ST_EDGE_W1;
				end else if (accept && in_op == scc_pkg::OP_EVAL) begin
					state_d = scc_pkg::ST_P1_SEL;
				end
			end
			scc_pkg::ST_EDGE_W1: state_d = scc_pkg::ST_EDGE_R2;
			scc_pkg::ST_EDGE_R2: state_d = scc_pkg::ST_EDGE_W2;
			scc_pkg::ST_EDGE_W2: state_d = scc_pkg::ST_IDLE;
			scc_pkg::ST_P1_SEL: begin
				state_d = cand_any ? scc_pkg::ST_P1_EXP : scc_pkg::ST_P2_INIT;
			end
			scc_pkg::ST_P1_EXP: begin
				if (!cand_any) begin
					state_d = (sp_q != '0) ? scc_pkg::ST_P1_POP : scc_pkg::ST_P1_SEL;
				end
			end
			scc_pkg::ST_P1_POP: state_d = scc_pkg::ST_P1_EXP;
			scc_pkg::ST_P2_INIT: begin
				state_d = (fin_q != '0) ? scc_pkg::ST_P2_S : scc_pkg::ST_DONE;
			end
			scc_pkg::ST_P2_S: begin
				if (!s_seen) begin
					state_d = scc_pkg::ST_P2_EXP;
				end else if (fin_q == '0) begin
					state_d = scc_pkg::ST_DONE;
				end
			end
			scc_pkg::ST_P2_EXP: begin
				if (!cand_any) begin
					state_d = (fin_q != '0) ? scc_pkg::ST_P2_S : scc_pkg::ST_DONE;
				end
			end
			scc_pkg::ST_DONE: begin
				if (res_ack) begin
					state_d = scc_pkg::ST_IDLE;
				end
			end
			default: state_d = scc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = '0;
		wr_addr        = '0;
		wr_data        = '0;
		base_we        = 1'b0;
		qry_we         = 1'b0;
		qry_clr        = 1'b0;
		res.valid      = 1'b0;
		res.area_count = scc_pkg::AreaW'(count_q);
		unique case (state_q)
			scc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && edge_ok) begin
					rd_en   = 1'b1;
					rd_addr = in_from_a;
				end
			end
			scc_pkg::ST_EDGE_W1: begin
				wr_addr = from_q;
				wr_data = rd_sel | (RowOne << to_q);
				base_we = op_q == scc_pkg::OP_BASE;
				qry_we  = op_q == scc_pkg::OP_QUERY;
			end
			scc_pkg::ST_EDGE_R2: begin
				rd_en   = 1'b1;
				rd_addr = to_q;
			end
			scc_pkg::ST_EDGE_W2: begin
				wr_addr = to_q;
				wr_data = rd_sel | (RowOne << (N + int'(from_q)));
				base_we = op_q == scc_pkg::OP_BASE;
				qry_we  = op_q == scc_pkg::OP_QUERY;
			end
			scc_pkg::ST_P1_SEL, scc_pkg::ST_P1_EXP, scc_pkg::ST_P2_EXP: begin
				rd_en   = cand_any;
				rd_addr = first;
			end
			scc_pkg::ST_P1_POP: begin
				rd_en   = 1'b1;
				rd_addr = stk_rd_q;
			end
			scc_pkg::ST_P2_S: begin
				rd_en   = !s_seen;
				rd_addr = fin_rd_q;
			end
			scc_pkg::ST_DONE: begin
				res.valid = 1'b1;
				qry_clr   = res_ack;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= scc_pkg::ST_IDLE;
			extra_q   <= '0;
			visited_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				scc_pkg::ST_IDLE: begin
					if (accept && edge_ok && in_op == scc_pkg::OP_QUERY) begin
						extra_q[in_from_a] <= 1'b1;
						extra_q[in_to_a]   <= 1'b1;
					end
					if (accept && in_op == scc_pkg::OP_EVAL) begin
						visited_q <= '0;
					end
				end
				scc_pkg::ST_P1_SEL, scc_pkg::ST_P1_EXP: begin
					if (cand_any) begin
						visited_q[first] <= 1'b1;
					end
				end
				scc_pkg::ST_P2_INIT: visited_q <= '0;
				scc_pkg::ST_P2_S: begin
					if (!s_seen) begin
						visited_q[fin_rd_q] <= 1'b1;
					end
				end
				scc_pkg::ST_P2_EXP: visited_q <= visited_q | newb;
				scc_pkg::ST_DONE: begin
					if (res_ack) begin
						extra_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			from_q <= in_from_a;
			to_q   <= in_to_a;
		end
		if (accept && in_op == scc_pkg::OP_EVAL) begin
			fin_q   <= '0;
			count_q <= '0;
		end
		if (state_q == scc_pkg::ST_P1_SEL && cand_any) begin
			top_q <= first;
			sp_q  <= '0;
		end
		if (state_q == scc_pkg::ST_P1_EXP) begin
			if (cand_any) begin
				stk_mem[sp_q] <= top_q;
				sp_q          <= sp_q + 1'b1;
				top_q         <= first;
			end else begin
				fin_mem[fin_q[VW-1:0]] <= top_q;
				fin_q                  <= fin_q + 1'b1;
				if (sp_q != '0) begin
					sp_q <= sp_dec;
				end
			end
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[sp_dec];
		end
		if (state_q == scc_pkg::ST_P1_POP) begin
			top_q <= stk_rd_q;
		end
		if (fin_re) begin
			fin_rd_q <= fin_mem[fin_dec[VW-1:0]];
			fin_q    <= fin_dec;
		end
		if (state_q == scc_pkg::ST_P2_S && !s_seen) begin
			count_q <= count_q + 1'b1;
			pend_q  <= '0;
		end
		if (state_q == scc_pkg::ST_P2_EXP && cand_any) begin
			pend_q <= cand & ~(VecOne << first);
		end
	end

endmodule

FILE: hw/rtl/scc_area_counter.sv
// Counts the strongly connected components of a stored base graph joined with the query
// edges loaded since the last evaluate. Each transfer with tuser 0 or 1 adds an edge, as
// it updates the source row and the destination row of an adjacency memory through two
// read-modify-write passes; an edge with an endpoint outside the store and tuser 3 are
// accepted and dropped. An evaluate (tuser 2) runs a forward depth-first search and a
// reverse search over the memories, reading one adjacency row per step; its count leaves
// on the output after that and the query edges and new places are then dropped. There is
// no clearing pass after reset.
module scc_area_counter #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [scc_pkg::PlacesW-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // from_vertex, to_vertex
	input  logic [1:0]                  s_tuser,  // op
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata   // area_count
);

	localparam int N  = MAX_VERTICES;
	localparam int VW = $clog2(MAX_VERTICES);

	logic [N-1:0]                place_mask_q;
	logic                        m_tvalid_q;
	logic [scc_pkg::AreaW-1:0]   area_q;
	scc_pkg::res_t               res;
	logic                        res_ack;
	logic                        rd_en, base_we, qry_we, qry_clr;
	logic [VW-1:0]               rd_addr, wr_addr;
	logic [2*N-1:0]              wr_data, base_rd, qry_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_mask_q <= '0;
		end else if (cfg_wen) begin
			for (int i = 0; i < N; i++) begin
				place_mask_q[i] <= 32'(i) < 32'(cfg_wdata);
			end
		end
	end

	assign res_ack = res.valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			area_q <= res.area_count;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, area_q};

	scc_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_from    (s_tdata[5:0]),
		.in_to      (s_tdata[11:6]),
		.place_mask (place_mask_q),
		.res        (res),
		.res_ack    (res_ack),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.base_we    (base_we),
		.qry_we     (qry_we),
		.qry_clr    (qry_clr),
		.base_rd    (base_rd),
		.qry_rd     (qry_rd)
	);

	scc_adj_ram #(.MAX_VERTICES(MAX_VERTICES)) u_base_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (1'b0),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.we      (base_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (base_rd)
	);

	scc_adj_ram #(.MAX_VERTICES(MAX_VERTICES)) u_qry_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (qry_clr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.we      (qry_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (qry_rd)
	);

endmodule

FILE: hw/rtl/scc_chk.sv
module scc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A result that waits must hold its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only an evaluate can bring out a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != scc_pkg::OP_EVAL && !m_tvalid |=> !m_tvalid)
		else $error("result without evaluate");

	// The search holds off further input.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == scc_pkg::OP_EVAL |=> !s_tready)
		else $error("input taken during search");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == 1'b0)
		else $error("padding bit set");

endmodule

bind scc_area_counter scc_chk u_chk (.*);

FILE: bench/scc_area_checker.sv
module scc_area_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	output int          fail_count,
	output int          pending
);

	localparam int NV = 64;

	logic [NV-1:0] base_rows [NV];
	logic [NV-1:0] query_rows [NV];
	logic [NV-1:0] new_places;
	int            places;
	logic [6:0]    count_queue [$];

	function automatic logic [NV-1:0] live_mask();
		logic [NV-1:0] m;
		m = new_places;
		for (int i = 0; i < NV; i++)
			if (i < places)
				m[i] = 1'b1;
		return m;
	endfunction

	function automatic logic linked(int u, int v, logic [NV-1:0] live);
		if (!live[u] || !live[v])
			return 1'b0;
		return base_rows[u][v] | query_rows[u][v];
	endfunction

	function automatic logic [6:0] component_count();
		logic [NV-1:0] live, seen;
		int order [NV];
		int stack [NV];
		int done, depth, v, total;
		logic moved;
		live = live_mask();
		seen = '0;
		done = 0;
		total = 0;
		for (int s = 0; s < NV; s++) begin
			if (!live[s] || seen[s])
				continue;
			seen[s] = 1'b1;
			depth = 0;
			stack[depth++] = s;
			while (depth > 0) begin
				v = stack[depth-1];
				moved = 1'b0;
				for (int w = 0; w < NV; w++) begin
					if (!seen[w] && linked(v, w, live)) begin
						seen[w] = 1'b1;
						stack[depth++] = w;
						moved = 1'b1;
						break;
					end
				end
				if (!moved) begin
					depth--;
					order[done++] = v;
				end
			end
		end
		seen = '0;
		for (int k = done; k > 0; k--) begin
			if (seen[order[k-1]])
				continue;
			total++;
			seen[order[k-1]] = 1'b1;
			depth = 0;
			stack[depth++] = order[k-1];
			while (depth > 0) begin
				v = stack[--depth];
				for (int w = 0; w < NV; w++) begin
					if (!seen[w] && linked(w, v, live)) begin
						seen[w] = 1'b1;
						stack[depth++] = w;
					end
				end
			end
		end
		return total[6:0];
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		places = 0;
		new_places = '0;
		for (int i = 0; i < NV; i++) begin
			base_rows[i] = '0;
			query_rows[i] = '0;
		end
	end

	always @(posedge clk) begin
		int f, t;
		logic [6:0] want;
		if (arst_n) begin
			if (cfg_wen)
				places = (cfg_wdata > NV) ? NV : cfg_wdata;
			if (s_tvalid && s_tready) begin
				f = s_tdata[5:0];
				t = s_tdata[11:6];
				case (s_tuser)
					scc_pkg::OP_BASE: base_rows[f][t] = 1'b1;
					scc_pkg::OP_QUERY: begin
						query_rows[f][t] = 1'b1;
						new_places[f] = 1'b1;
						new_places[t] = 1'b1;
					end
					scc_pkg::OP_EVAL: begin
						count_queue.insert(count_queue.size(), component_count());
						new_places = '0;
						for (int i = 0; i < NV; i++)
							query_rows[i] = '0;
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (count_queue.size() == 0) begin
					report_mismatch("unexpected area_count", m_tdata, -1);
				end else begin
					want = count_queue.pop_front();
					if (m_tdata !== {1'b0, want})
						report_mismatch("area_count", m_tdata, want);
				end
			end
			pending <= count_queue.size();
		end
	end
endmodule

FILE: bench/scc_area_counter_test.sv
module scc_area_counter_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          stall_mode = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	scc_area_counter dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	scc_area_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver cycles through phases: always ready, sparse stalls and heavy stalls.
	always @(posedge clk) begin
		if (cycles % 500 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_item(input logic [1:0] op, input logic [5:0] f, input logic [5:0] t);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, t, f};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (7 * 64 + 20) @(posedge clk);
	endtask

	task automatic set_places(input logic [6:0] p);
		cfg_wen <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_item(input int span);
		int r;
		logic [5:0] f, t;
		r = $urandom_range(0, 99);
		f = (span >= 64) ? 6'($urandom) : 6'($urandom_range(0, span - 1));
		t = (span >= 64) ? 6'($urandom) : 6'($urandom_range(0, span - 1));
		if (r < 45)
			send_item(scc_pkg::OP_BASE, f, t);
		else if (r < 80)
			send_item(scc_pkg::OP_QUERY, f, t);
		else if (r < 97)
			send_item(scc_pkg::OP_EVAL, 6'($urandom), 6'($urandom));
		else
			send_item(scc_pkg::OP_NOP, f, t);
	endtask

	initial begin
		logic [6:0] place_set [6];
		int burst, span;
		place_set = '{7'd0, 7'd64, 7'd127, 7'd8, 7'd20, 7'd65};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		send_item(scc_pkg::OP_QUERY, 6'd63, 6'd0);
		send_item(scc_pkg::OP_QUERY, 6'd0, 6'd63);
		send_item(scc_pkg::OP_EVAL, 6'd63, 6'd63);
		send_item(scc_pkg::OP_QUERY, 6'd5, 6'd5);
		send_item(scc_pkg::OP_NOP, 6'd63, 6'd63);
		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		drain();
		set_places(7'd64);
		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		send_item(scc_pkg::OP_BASE, 6'd0, 6'd1);
		send_item(scc_pkg::OP_BASE, 6'd1, 6'd0);
		send_item(scc_pkg::OP_BASE, 6'd2, 6'd2);
		send_item(scc_pkg::OP_BASE, 6'd63, 6'd62);
		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		drain();
		set_places(7'd4);
		send_item(scc_pkg::OP_BASE, 6'd3, 6'd40);
		send_item(scc_pkg::OP_BASE, 6'd40, 6'd3);
		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		send_item(scc_pkg::OP_QUERY, 6'd40, 6'd41);
		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			set_places(place_set[phase]);
			span = (phase % 2 == 0) ? 64 : 12;
			for (int n = 0; n < 280; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < 280; b++, n++)
					random_item(span);
				if ($urandom_range(0, 2) == 0)
					pause($urandom_range(1, 10));
				if (n == 140 && phase == 2) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			send_item(scc_pkg::OP_EVAL, 6'd0, 6'd0);
			drain();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/scc_pkg.sv
hw/rtl/scc_adj_ram.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_area_counter.sv
hw/rtl/scc_chk.sv
bench/scc_area_checker.sv
bench/scc_area_counter_test.sv
